/* hw/rtl/mvna_pkg.sv */
// Shared types, constants and command codes of the vertex normal accumulator.
`default_nettype none
package mvna_pkg;

   localparam int MAX_VERTICES_DEF = 1024;

   localparam int IDX_W = 10;
   localparam int POS_W = 32;
   localparam int NRM_W = 16;

   localparam int EDGE_W  = 33;
   localparam int SEDGE_W = 31;
   localparam int PROD_W  = 62;
   localparam int VEC_W   = 62;
   localparam int MAG_W   = 62;
   localparam int SH_W    = 20;
   localparam int COARSE  = 8;
   localparam int SQ_W    = 2 * SH_W;
   localparam int SUM_W   = 42;
   localparam int ROOT_W  = 21;
   localparam int SREM_W  = 24;
   localparam int QUO_W   = 15;
   localparam int REM_W   = 22;
   localparam int IT_W    = 5;

   localparam int Q_DEPTH = 2;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_TRI  = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;
   localparam logic [1:0] FUNC_INV  = 2'd3;

   typedef struct packed {
      logic [1:0]              func;
      logic [IDX_W-1:0]        vertex_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [NRM_W-1:0] init_norm_x;
      logic signed [NRM_W-1:0] init_norm_y;
      logic signed [NRM_W-1:0] init_norm_z;
      logic [IDX_W-1:0]        corner_a;
      logic [IDX_W-1:0]        corner_b;
      logic [IDX_W-1:0]        corner_c;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        read_index;
      logic signed [NRM_W-1:0] out_norm_x;
      logic signed [NRM_W-1:0] out_norm_y;
      logic signed [NRM_W-1:0] out_norm_z;
   } rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } pos_type;

   typedef struct packed {
      logic signed [NRM_W-1:0] x;
      logic signed [NRM_W-1:0] y;
      logic signed [NRM_W-1:0] z;
   } nrm_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic [1:0]       op;
      logic             ok;
      logic [IDX_W-1:0] idx_a;
      logic [IDX_W-1:0] idx_b;
      logic [IDX_W-1:0] idx_c;
      pos_type          pos;
      nrm_type          nrm;
   } cmd_type;

endpackage
`default_nettype wire

/* hw/rtl/mesh_vertex_normal_accumulator.sv */
// Top level of the mesh vertex normal accumulator.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    req_data (req_type)
//   rsp_      out         rsp_valid/rsp_ready    rsp_data (rsp_type)
//
// Every beat passes through the registered queue. A load or an invert is then done by the
// execution unit as it pops the beat, and a read passes a table-read state and a response state.
// A triangle holds the execution unit while the shared normalizer runs for its face normal and
// for each corner sum (one root bit and one quotient bit a cycle); a zero vector skips the
// normalizer's scaling, square root and division steps.
// Invert is a single flag flip, so no table sweep follows it or reset.
// A two-beat queue takes requests while the execution unit works.
// A waiting response stalls only the next read.
`default_nettype none
module mesh_vertex_normal_accumulator
   import mvna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    q_full, q_push, q_pop, q_valid;
   cmd_type push_cmd, pop_cmd;

   mvna_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   mvna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   mvna_back #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* hw/rtl/mvna_front.sv */
// Front end: accepts request beats and decodes them into queued commands.
`default_nettype none
module mvna_front
   import mvna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         q_push,
   output cmd_type      q_cmd
);

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      in_range = (32'(idx) < 32'(MAX_VERTICES));
   endfunction

   always_comb begin
      req_ready       = !q_full;
      q_push          = req_valid && !q_full;
      q_cmd.op        = req_data.func;
      q_cmd.idx_b     = req_data.corner_b;
      q_cmd.idx_c     = req_data.corner_c;
      q_cmd.pos.x     = req_data.pos_x;
      q_cmd.pos.y     = req_data.pos_y;
      q_cmd.pos.z     = req_data.pos_z;
      q_cmd.nrm.x     = req_data.init_norm_x;
      q_cmd.nrm.y     = req_data.init_norm_y;
      q_cmd.nrm.z     = req_data.init_norm_z;
      q_cmd.idx_a     = req_data.vertex_index;
      q_cmd.ok        = 1'b1;
      case (req_data.func)
         FUNC_LOAD, FUNC_READ: begin
            q_cmd.ok = in_range(req_data.vertex_index);
         end
         FUNC_TRI: begin
            q_cmd.idx_a = req_data.corner_a;
            q_cmd.ok    = in_range(req_data.corner_a) && in_range(req_data.corner_b)
                          && in_range(req_data.corner_c);
         end
         default: begin
            q_cmd.ok = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/mvna_queue.sv */
// Short command queue between the front end and the execution unit.
`default_nettype none
module mvna_queue
   import mvna_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_cmd
);

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   cmd_type         q_ff [Q_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      full      = (cnt_ff == CW'(Q_DEPTH));
      pop_valid = (cnt_ff != '0);
      pop_cmd   = q_ff[rd_ff];
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/mvna_norm.sv */
// Iterative vector normalizer: scaling, sum of squares, square root and division.
`default_nettype none
module mvna_norm
   import mvna_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire vec_type vec,
   output logic         done,
   output nrm_type      nrm
);

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_ACC   = 3'd3;
   localparam logic [2:0] N_SQRT  = 3'd4;
   localparam logic [2:0] N_DPREP = 3'd5;
   localparam logic [2:0] N_DIV   = 3'd6;
   localparam logic [2:0] N_OUT   = 3'd7;

   logic [2:0]              st_ff, st_in;
   logic                    sign_ff [3];
   logic                    sign_in [3];
   logic [MAG_W-1:0]        mag_ff [3];
   logic [MAG_W-1:0]        mag_in [3];
   logic signed [NRM_W-1:0] res_ff [3];
   logic signed [NRM_W-1:0] res_in [3];
   logic signed [VEC_W-1:0] vin [3];
   logic [1:0]              cnt_ff, cnt_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [SREM_W-1:0]       srem_ff, srem_in;
   logic [IT_W-1:0]         it_ff, it_in;
   logic [REM_W-1:0]        drem_ff, drem_in;
   logic [QUO_W-1:0]        dnum_ff, dnum_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [MAG_W-1:0]        m_or;
   logic [SREM_W-1:0]       sq_t, sq_trial;
   logic [REM_W-1:0]        dv_t;
   logic                    dv_ge;
   logic [QUO_W-1:0]        q_fin;

   always_comb begin
      vin[0]   = vec.x;
      vin[1]   = vec.y;
      vin[2]   = vec.z;
      st_in    = st_ff;
      sign_in  = sign_ff;
      mag_in   = mag_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      sq_in    = sq_ff;
      sum_in   = sum_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      it_in    = it_ff;
      drem_in  = drem_ff;
      dnum_in  = dnum_ff;
      quo_in   = quo_ff;
      m_or     = mag_ff[0] | mag_ff[1] | mag_ff[2];
      sq_t     = {srem_ff[SREM_W-3:0], sum_ff[SUM_W-1 -: 2]};
      sq_trial = SREM_W'({root_ff, 2'b01});
      dv_t     = {drem_ff[REM_W-2:0], dnum_ff[QUO_W-1]};
      dv_ge    = (dv_t >= REM_W'(root_ff));
      q_fin    = {quo_ff[QUO_W-2:0], dv_ge};
      case (st_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  sign_in[i] = vin[i][VEC_W-1];
                  mag_in[i]  = vin[i][VEC_W-1] ? MAG_W'(-vin[i]) : MAG_W'(vin[i]);
                  res_in[i]  = '0;
               end
               sum_in = '0;
               cnt_in = '0;
               if (vec.x == '0 && vec.y == '0 && vec.z == '0) begin
                  st_in = N_OUT;
               end else begin
                  st_in = N_SHIFT;
               end
            end
         end
         N_SHIFT: begin
            if (|m_or[MAG_W-1:SH_W+COARSE]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> COARSE;
            end else if (|m_or[MAG_W-1:SH_W]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (!(|m_or[SH_W-1:SH_W-COARSE])) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << COARSE;
            end else if (!m_or[SH_W-1]) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               st_in = N_SQ;
            end
         end
         N_SQ: begin
            sq_in = mag_ff[cnt_ff][SH_W-1:0] * mag_ff[cnt_ff][SH_W-1:0];
            st_in = N_ACC;
         end
         N_ACC: begin
            sum_in = sum_ff + SUM_W'(sq_ff);
            if (cnt_ff == 2'd2) begin
               cnt_in  = '0;
               root_in = '0;
               srem_in = '0;
               it_in   = '0;
               st_in   = N_SQRT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               st_in  = N_SQ;
            end
         end
         N_SQRT: begin
            if (sq_t >= sq_trial) begin
               srem_in = sq_t - sq_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = sq_t;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            sum_in = sum_ff << 2;
            it_in  = it_ff + 1'b1;
            if (it_ff == IT_W'(ROOT_W - 1)) begin
               st_in = N_DPREP;
            end
         end
         N_DPREP: begin
            drem_in = REM_W'(mag_ff[cnt_ff][SH_W-1:1]);
            dnum_in = {mag_ff[cnt_ff][0], (QUO_W-1)'(0)};
            quo_in  = '0;
            it_in   = '0;
            st_in   = N_DIV;
         end
         N_DIV: begin
            drem_in = dv_ge ? dv_t - REM_W'(root_ff) : dv_t;
            dnum_in = dnum_ff << 1;
            quo_in  = q_fin;
            it_in   = it_ff + 1'b1;
            if (it_ff == IT_W'(QUO_W - 1)) begin
               res_in[cnt_ff] = sign_ff[cnt_ff] ? -NRM_W'(q_fin) : NRM_W'(q_fin);
               if (cnt_ff == 2'd2) begin
                  st_in = N_OUT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
                  st_in  = N_DPREP;
               end
            end
         end
         N_OUT: begin
            st_in = N_IDLE;
         end
         default: begin
            st_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= N_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff <= sign_in;
      mag_ff  <= mag_in;
      res_ff  <= res_in;
      cnt_ff  <= cnt_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      it_ff   <= it_in;
      drem_ff <= drem_in;
      dnum_ff <= dnum_in;
      quo_ff  <= quo_in;
   end

   assign done  = (st_ff == N_OUT);
   assign nrm.x = res_ff[0];
   assign nrm.y = res_ff[1];
   assign nrm.z = res_ff[2];

endmodule
`default_nettype wire

/* hw/rtl/mvna_back.sv */
// Execution unit: vertex tables, face normal, corner updates and the result register.
`default_nettype none
module mvna_back
   import mvna_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(MAX_VERTICES);

   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_RD    = 4'd1;
   localparam logic [3:0] B_RSP   = 4'd2;
   localparam logic [3:0] B_TA    = 4'd3;
   localparam logic [3:0] B_TB    = 4'd4;
   localparam logic [3:0] B_TC    = 4'd5;
   localparam logic [3:0] B_TD    = 4'd6;
   localparam logic [3:0] B_SCALE = 4'd7;
   localparam logic [3:0] B_MUL   = 4'd8;
   localparam logic [3:0] B_ACC   = 4'd9;
   localparam logic [3:0] B_FNS   = 4'd10;
   localparam logic [3:0] B_FN    = 4'd11;
   localparam logic [3:0] B_CRD   = 4'd12;
   localparam logic [3:0] B_CSUM  = 4'd13;
   localparam logic [3:0] B_CWAIT = 4'd14;

   typedef struct packed {
      logic signed [EDGE_W-1:0] x;
      logic signed [EDGE_W-1:0] y;
      logic signed [EDGE_W-1:0] z;
   } diff_type;

   typedef struct packed {
      logic signed [SEDGE_W-1:0] x;
      logic signed [SEDGE_W-1:0] y;
      logic signed [SEDGE_W-1:0] z;
   } edge_type;

   function automatic nrm_type neg_nrm(input nrm_type v);
      neg_nrm.x = -v.x;
      neg_nrm.y = -v.y;
      neg_nrm.z = -v.z;
   endfunction

   function automatic logic signed [SEDGE_W-1:0] shrink(input logic signed [EDGE_W-1:0] d,
                                                        input logic [1:0] sh);
      logic [EDGE_W-1:0] m;
      logic [EDGE_W-1:0] s;
      m = d[EDGE_W-1] ? EDGE_W'(-d) : EDGE_W'(d);
      s = m >> sh;
      shrink = d[EDGE_W-1] ? -s[SEDGE_W-1:0] : s[SEDGE_W-1:0];
   endfunction

   function automatic logic [EDGE_W-1:0] mag_of(input logic signed [EDGE_W-1:0] d);
      mag_of = d[EDGE_W-1] ? EDGE_W'(-d) : EDGE_W'(d);
   endfunction

   pos_type                  pos_mem_ff [MAX_VERTICES];
   nrm_type                  nrm_mem_ff [MAX_VERTICES];
   pos_type                  pos_rd_ff;
   nrm_type                  nrm_rd_ff;

   logic [3:0]               state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic                     inv_ff, inv_in;
   pos_type                  pa_ff, pa_in, pb_ff, pb_in;
   diff_type                 d1_ff, d1_in, d2_ff, d2_in;
   edge_type                 e1_ff, e1_in, e2_ff, e2_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   vec_type                  f_ff, f_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [1:0]               k_ff, k_in;
   nrm_type                  fn_ff, fn_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]          corner_idx;
   logic [IDX_W-1:0]          rd_idx;
   logic                      pos_we, nrm_we;
   logic [IDX_W-1:0]          nrm_widx;
   nrm_type                   nrm_wd;
   nrm_type                   nrm_cur;
   logic [EDGE_W-1:0]         e_or;
   logic [1:0]                e_sh;
   logic signed [SEDGE_W-1:0] op_a, op_b;
   logic signed [NRM_W:0]     s_x, s_y, s_z;
   logic                      norm_start;
   vec_type                   norm_vec;
   logic                      norm_done;
   nrm_type                   norm_res;

   mvna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec   (norm_vec),
      .done  (norm_done),
      .nrm   (norm_res)
   );

   always_comb begin
      case (k_ff)
         2'd0:    corner_idx = cmd_ff.idx_a;
         2'd1:    corner_idx = cmd_ff.idx_b;
         default: corner_idx = cmd_ff.idx_c;
      endcase
      case (state_ff)
         B_TB:         rd_idx = cmd_ff.idx_b;
         B_TC:         rd_idx = cmd_ff.idx_c;
         B_CRD, B_CSUM: rd_idx = corner_idx;
         default:      rd_idx = cmd_ff.idx_a;
      endcase
      nrm_cur = inv_ff ? neg_nrm(nrm_rd_ff) : nrm_rd_ff;
      e_or = mag_of(d1_ff.x) | mag_of(d1_ff.y) | mag_of(d1_ff.z)
             | mag_of(d2_ff.x) | mag_of(d2_ff.y) | mag_of(d2_ff.z);
      e_sh = e_or[POS_W-1] ? 2'd2 : (e_or[POS_W-2] ? 2'd1 : 2'd0);
      case (cnt_ff)
         3'd0: begin op_a = e1_ff.y; op_b = e2_ff.z; end
         3'd1: begin op_a = e1_ff.z; op_b = e2_ff.y; end
         3'd2: begin op_a = e1_ff.z; op_b = e2_ff.x; end
         3'd3: begin op_a = e1_ff.x; op_b = e2_ff.z; end
         3'd4: begin op_a = e1_ff.x; op_b = e2_ff.y; end
         3'd5: begin op_a = e1_ff.y; op_b = e2_ff.x; end
         default: begin op_a = '0; op_b = '0; end
      endcase
      s_x = {nrm_cur.x[NRM_W-1], nrm_cur.x} + {fn_ff.x[NRM_W-1], fn_ff.x};
      s_y = {nrm_cur.y[NRM_W-1], nrm_cur.y} + {fn_ff.y[NRM_W-1], fn_ff.y};
      s_z = {nrm_cur.z[NRM_W-1], nrm_cur.z} + {fn_ff.z[NRM_W-1], fn_ff.z};
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      inv_in       = inv_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      prod_in      = prod_ff;
      f_in         = f_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      fn_in        = fn_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      pos_we       = 1'b0;
      nrm_we       = 1'b0;
      nrm_widx     = q_cmd.idx_a;
      nrm_wd       = inv_ff ? neg_nrm(q_cmd.nrm) : q_cmd.nrm;
      norm_start   = 1'b0;
      norm_vec     = f_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               case (q_cmd.op)
                  FUNC_LOAD: begin
                     pos_we = q_cmd.ok;
                     nrm_we = q_cmd.ok;
                  end
                  FUNC_TRI: begin
                     if (q_cmd.ok) begin
                        state_in = B_TA;
                     end
                  end
                  FUNC_READ: begin
                     state_in = q_cmd.ok ? B_RD : B_RSP;
                  end
                  default: begin
                     inv_in = !inv_ff;
                  end
               endcase
            end
         end
         B_RD: begin
            state_in = B_RSP;
         end
         B_RSP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.read_index = cmd_ff.idx_a;
               rsp_data_in.out_norm_x = cmd_ff.ok ? nrm_cur.x : '0;
               rsp_data_in.out_norm_y = cmd_ff.ok ? nrm_cur.y : '0;
               rsp_data_in.out_norm_z = cmd_ff.ok ? nrm_cur.z : '0;
               state_in               = B_IDLE;
            end
         end
         B_TA: begin
            state_in = B_TB;
         end
         B_TB: begin
            pa_in    = pos_rd_ff;
            state_in = B_TC;
         end
         B_TC: begin
            pb_in    = pos_rd_ff;
            state_in = B_TD;
         end
         B_TD: begin
            d1_in.x  = {pa_ff.x[POS_W-1], pa_ff.x} - {pos_rd_ff.x[POS_W-1], pos_rd_ff.x};
            d1_in.y  = {pa_ff.y[POS_W-1], pa_ff.y} - {pos_rd_ff.y[POS_W-1], pos_rd_ff.y};
            d1_in.z  = {pa_ff.z[POS_W-1], pa_ff.z} - {pos_rd_ff.z[POS_W-1], pos_rd_ff.z};
            d2_in.x  = {pb_ff.x[POS_W-1], pb_ff.x} - {pa_ff.x[POS_W-1], pa_ff.x};
            d2_in.y  = {pb_ff.y[POS_W-1], pb_ff.y} - {pa_ff.y[POS_W-1], pa_ff.y};
            d2_in.z  = {pb_ff.z[POS_W-1], pb_ff.z} - {pa_ff.z[POS_W-1], pa_ff.z};
            state_in = B_SCALE;
         end
         B_SCALE: begin
            e1_in.x  = shrink(d1_ff.x, e_sh);
            e1_in.y  = shrink(d1_ff.y, e_sh);
            e1_in.z  = shrink(d1_ff.z, e_sh);
            e2_in.x  = shrink(d2_ff.x, e_sh);
            e2_in.y  = shrink(d2_ff.y, e_sh);
            e2_in.z  = shrink(d2_ff.z, e_sh);
            cnt_in   = '0;
            state_in = B_MUL;
         end
         B_MUL: begin
            prod_in  = PROD_W'(op_a) * PROD_W'(op_b);
            state_in = B_ACC;
         end
         B_ACC: begin
            case (cnt_ff)
               3'd0:    f_in.x = prod_ff;
               3'd1:    f_in.x = f_ff.x - prod_ff;
               3'd2:    f_in.y = prod_ff;
               3'd3:    f_in.y = f_ff.y - prod_ff;
               3'd4:    f_in.z = prod_ff;
               default: f_in.z = f_ff.z - prod_ff;
            endcase
            if (cnt_ff == 3'd5) begin
               state_in = B_FNS;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = B_MUL;
            end
         end
         B_FNS: begin
            norm_start = 1'b1;
            norm_vec   = f_ff;
            state_in   = B_FN;
         end
         B_FN: begin
            if (norm_done) begin
               fn_in    = norm_res;
               k_in     = '0;
               state_in = B_CRD;
            end
         end
         B_CRD: begin
            state_in = B_CSUM;
         end
         B_CSUM: begin
            norm_start = 1'b1;
            norm_vec.x = VEC_W'(s_x);
            norm_vec.y = VEC_W'(s_y);
            norm_vec.z = VEC_W'(s_z);
            state_in   = B_CWAIT;
         end
         B_CWAIT: begin
            if (norm_done) begin
               nrm_we   = 1'b1;
               nrm_widx = corner_idx;
               nrm_wd   = inv_ff ? neg_nrm(norm_res) : norm_res;
               if (k_ff == 2'd2) begin
                  state_in = B_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = B_CRD;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      d1_ff       <= d1_in;
      d2_ff       <= d2_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      prod_ff     <= prod_in;
      f_ff        <= f_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      fn_ff       <= fn_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem_ff[AW'(q_cmd.idx_a)] <= q_cmd.pos;
      end
      pos_rd_ff <= pos_mem_ff[AW'(rd_idx)];
   end

   always_ff @(posedge clock) begin
      if (nrm_we) begin
         nrm_mem_ff[AW'(nrm_widx)] <= nrm_wd;
      end
      nrm_rd_ff <= nrm_mem_ff[AW'(rd_idx)];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
